// ===== hdl/quaternion_alu_assert.svh =====
// assertion macros used by the quaternion unit port checks
`ifndef QUATERNION_ALU_ASSERT_SVH
`define QUATERNION_ALU_ASSERT_SVH

// condition holds in the same cycle as its trigger
`define QALU_AST_SAME(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("quaternion_alu check failed");

// condition holds in the cycle after its trigger
`define QALU_AST_NEXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("quaternion_alu check failed");

// condition holds in the cycle after reset is seen
`define QALU_AST_RESET(lbl, ck, rs, c) \
  lbl: assert property (@(posedge ck) (rs) |=> (c)) \
    else $error("quaternion_alu reset check failed");

`endif

// ===== hdl/qalu_pkg.sv =====
// ----------------------------------------------------------------------------
// qalu_pkg
// shared types, codes and helpers of the quaternion arithmetic unit
// ----------------------------------------------------------------------------
package qalu_pkg;

  localparam int COMP_WIDTH      = 16;
  localparam int FRAC_BITS_DEF   = 14;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [2:0] {
    OP_CONJ = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_ERR  = 3'd4,
    OP_NORM = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    CL_NONE,
    CL_CONJ,
    CL_ADD,
    CL_SUB,
    CL_MUL,
    CL_ERR,
    CL_NORM
  } cls_t;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  // index 0 x, 1 y, 2 z, 3 w
  typedef logic [3:0][COMP_WIDTH-1:0] quat_t;

  typedef struct packed {
    logic [2:0] op;
    comp_t      a_x;
    comp_t      a_y;
    comp_t      a_z;
    comp_t      a_w;
    comp_t      b_x;
    comp_t      b_y;
    comp_t      b_z;
    comp_t      b_w;
  } req_t;

  typedef struct packed {
    comp_t r_x;
    comp_t r_y;
    comp_t r_z;
    comp_t r_w;
    logic  zero_norm;
  } rsp_t;

  typedef struct packed {
    cls_t  cls;
    quat_t a;
    quat_t b;
  } work_t;

  // clamp to the signed component range
  function automatic comp_t sat_comp(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (COMP_WIDTH - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return comp_t'(hi);
    end else if (v < lo) begin
      return comp_t'(lo);
    end
    return comp_t'(v);
  endfunction

endpackage

// ===== hdl/qalu_fifo.sv =====
// ----------------------------------------------------------------------------
// qalu_fifo
// small register queue between the front and back parts
// ----------------------------------------------------------------------------
module qalu_fifo #(
  parameter int W     = 1,
  parameter int DEPTH = qalu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] dout
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CTW = $clog2(DEPTH + 1);

  logic [W-1:0]   mem [DEPTH];
  logic [AW-1:0]  wp;
  logic [AW-1:0]  rp;
  logic [CTW-1:0] cnt;
  logic           do_push;
  logic           do_pop;

  assign full    = (cnt == CTW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= din;
    end
  end

endmodule

// ===== hdl/qalu_front.sv =====
// ----------------------------------------------------------------------------
// qalu_front
// accepts transactions, decodes the opcode into an operation class
// ----------------------------------------------------------------------------
module qalu_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  qalu_pkg::req_t   req,
  input  logic             q_full,
  output logic             q_push,
  output qalu_pkg::work_t  q_data
);

  logic            fv;
  qalu_pkg::work_t fw;
  qalu_pkg::cls_t  cls;
  logic            accept;

  always_comb begin
    case (qalu_pkg::op_t'(req.op))
      qalu_pkg::OP_CONJ: cls = qalu_pkg::CL_CONJ;
      qalu_pkg::OP_ADD:  cls = qalu_pkg::CL_ADD;
      qalu_pkg::OP_SUB:  cls = qalu_pkg::CL_SUB;
      qalu_pkg::OP_MUL:  cls = qalu_pkg::CL_MUL;
      qalu_pkg::OP_ERR:  cls = qalu_pkg::CL_ERR;
      qalu_pkg::OP_NORM: cls = qalu_pkg::CL_NORM;
      default:           cls = qalu_pkg::CL_NONE;
    endcase
  end

  assign q_push = fv && !q_full;
  assign full   = fv && q_full;
  assign accept = push && !full;
  assign q_data = fw;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (accept) begin
      fv <= 1'b1;
    end else if (q_push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fw.cls <= cls;
      fw.a   <= {req.a_w, req.a_z, req.a_y, req.a_x};
      fw.b   <= {req.b_w, req.b_z, req.b_y, req.b_x};
    end
  end

endmodule

// ===== hdl/qalu_norm.sv =====
// ----------------------------------------------------------------------------
// qalu_norm
// pipelined square root of the squared magnitude, then four dividers
// ----------------------------------------------------------------------------
module qalu_norm #(
  parameter int FRAC_BITS = qalu_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [2*qalu_pkg::COMP_WIDTH:0]    s,
  input  qalu_pkg::quat_t                    a,
  output qalu_pkg::quat_t                    r,
  output logic                               zero
);

  localparam int CW  = qalu_pkg::COMP_WIDTH;
  localparam int VW  = 2 * CW + 2;
  localparam int SQN = CW + 1;
  localparam int MW  = CW + 1;
  localparam int QB  = FRAC_BITS + 2;
  localparam int DW  = CW + FRAC_BITS + 1;
  localparam int XW  = CW + FRAC_BITS + 3;

  // root digit stages
  logic [VW-1:0]   sv [SQN];
  logic [VW-1:0]   sr [SQN];
  qalu_pkg::quat_t sa [SQN];

  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    localparam logic [VW-1:0] BIT = VW'(1) << (2 * (SQN - 1 - k));
    logic [VW-1:0]   vin;
    logic [VW-1:0]   rin;
    logic [VW-1:0]   t;
    qalu_pkg::quat_t ain;
    if (k == 0) begin : g_first
      assign vin = VW'(s);
      assign rin = '0;
      assign ain = a;
    end else begin : g_next
      assign vin = sv[k-1];
      assign rin = sr[k-1];
      assign ain = sa[k-1];
    end
    assign t = rin + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (vin >= t) begin
          sv[k] <= vin - t;
          sr[k] <= (rin >> 1) + BIT;
        end else begin
          sv[k] <= vin;
          sr[k] <= rin >> 1;
        end
        sa[k] <= ain;
      end
    end
  end

  // dividend setup, rounding half of the magnitude folded in
  logic [MW-1:0]         pm;
  logic [3:0]            pneg;
  logic [3:0][DW-1:0]    pd;
  logic                  pz;
  logic [MW-1:0]         mag;
  logic [3:0]            neg_c;
  logic [3:0][DW-1:0]    d_c;

  assign mag = sr[SQN-1][MW-1:0];

  always_comb begin
    logic signed [CW:0] c;
    logic [CW:0]        m;
    for (int i = 0; i < 4; i++) begin
      c        = (CW+1)'(signed'(sa[SQN-1][i]));
      neg_c[i] = c[CW];
      m        = c[CW] ? unsigned'(-c) : unsigned'(c);
      d_c[i]   = (DW'(m) << FRAC_BITS) + DW'(mag >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pm   <= mag;
      pneg <= neg_c;
      pd   <= d_c;
      pz   <= (mag == '0);
    end
  end

  // quotient bit stages
  logic [3:0][DW-1:0] dr   [QB];
  logic [3:0][QB-1:0] dq   [QB];
  logic [MW-1:0]      dm   [QB];
  logic [3:0]         dneg [QB];
  logic               dz   [QB];

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = QB - 1 - j;
    logic [3:0][DW-1:0] rin;
    logic [3:0][QB-1:0] qin;
    logic [MW-1:0]      min;
    logic [3:0]         nin;
    logic               zin;
    logic [3:0][DW-1:0] rn;
    logic [3:0][QB-1:0] qn;
    logic [XW-1:0]      dvs;
    if (j == 0) begin : g_first
      assign rin = pd;
      assign qin = '0;
      assign min = pm;
      assign nin = pneg;
      assign zin = pz;
    end else begin : g_next
      assign rin = dr[j-1];
      assign qin = dq[j-1];
      assign min = dm[j-1];
      assign nin = dneg[j-1];
      assign zin = dz[j-1];
    end
    assign dvs = XW'(min) << K;
    always_comb begin
      logic ge;
      for (int i = 0; i < 4; i++) begin
        ge    = (XW'(rin[i]) >= dvs);
        rn[i] = ge ? DW'(XW'(rin[i]) - dvs) : rin[i];
        qn[i] = {qin[i][QB-2:0], ge};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dr[j]   <= rn;
        dq[j]   <= qn;
        dm[j]   <= min;
        dneg[j] <= nin;
        dz[j]   <= zin;
      end
    end
  end

  // sign and clamp
  always_comb begin
    logic [63:0] q;
    for (int i = 0; i < 4; i++) begin
      q    = 64'(dq[QB-1][i]);
      r[i] = dz[QB-1] ? '0 : qalu_pkg::sat_comp(dneg[QB-1][i] ? -q : q);
    end
  end

  assign zero = dz[QB-1];

endmodule

// ===== hdl/qalu_back.sv =====
// ----------------------------------------------------------------------------
// qalu_back
// execution pipeline: products, sums with rounding, normalize path, output
// ----------------------------------------------------------------------------
module qalu_back #(
  parameter int FRAC_BITS = qalu_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  qalu_pkg::work_t q_data,
  output logic            q_pop,
  output logic            empty,
  input  logic            pop,
  output qalu_pkg::rsp_t  rsp
);

  localparam int CW = qalu_pkg::COMP_WIDTH;
  localparam int PW = 2 * CW;
  localparam int RW = PW + 3;
  localparam int SW = 2 * CW + 1;
  localparam int NL = (CW + 1) + 1 + (FRAC_BITS + 2);
  localparam logic signed [RW-1:0] HALF = RW'(1) << (FRAC_BITS - 1);

  logic en;
  logic out_v;

  assign en    = !out_v || pop;
  assign q_pop = en && !q_empty;
  assign empty = !out_v;

  // stage 1: operands
  logic            v1;
  qalu_pkg::cls_t  cls1;
  qalu_pkg::quat_t a1;
  qalu_pkg::quat_t b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls1 <= q_data.cls;
      a1   <= q_data.a;
      b1   <= q_data.b;
    end
  end

  // stage 2: products, squares and the linear ops
  logic                 v2;
  qalu_pkg::cls_t       cls2;
  qalu_pkg::quat_t      a2;
  qalu_pkg::quat_t      simp2;
  qalu_pkg::quat_t      simp_c;
  logic signed [PW-1:0] p2  [4][4];
  logic signed [PW-1:0] sq2 [4];

  always_comb begin
    logic signed [CW:0] ae;
    logic signed [CW:0] be;
    logic signed [CW:0] sm;
    for (int i = 0; i < 4; i++) begin
      ae = (CW+1)'(signed'(a1[i]));
      be = (CW+1)'(signed'(b1[i]));
      case (cls1)
        qalu_pkg::CL_CONJ: sm = (i == 3) ? ae : -ae;
        qalu_pkg::CL_ADD:  sm = ae + be;
        qalu_pkg::CL_SUB:  sm = ae - be;
        default:           sm = '0;
      endcase
      simp_c[i] = qalu_pkg::sat_comp(64'(sm));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls2  <= cls1;
      a2    <= a1;
      simp2 <= simp_c;
      for (int i = 0; i < 4; i++) begin
        sq2[i] <= signed'(a1[i]) * signed'(a1[i]);
        for (int j = 0; j < 4; j++) begin
          p2[i][j] <= signed'(a1[i]) * signed'(b1[j]);
        end
      end
    end
  end

  // stage 3: four-term sums, round half up, clamp; squared magnitude
  logic signed [RW-1:0] e   [4][4];
  logic signed [RW-1:0] acc [4];
  qalu_pkg::quat_t      prod_c;
  qalu_pkg::quat_t      res_c;
  logic [SW-1:0]        s_c;
  logic                 is_err;

  assign is_err = (cls2 == qalu_pkg::CL_ERR);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        e[i][j] = RW'(p2[i][j]);
      end
    end
    // error product flips the sign of the a_w term on the vector part and of the vector terms in w
    acc[0] = (is_err ? -e[3][0] : e[3][0]) + e[0][3] + e[1][2] - e[2][1];
    acc[1] = (is_err ? -e[3][1] : e[3][1]) + e[1][3] + e[2][0] - e[0][2];
    acc[2] = (is_err ? -e[3][2] : e[3][2]) + e[2][3] + e[0][1] - e[1][0];
    acc[3] = is_err ? (e[3][3] + e[0][0] + e[1][1] + e[2][2])
                    : (e[3][3] - e[0][0] - e[1][1] - e[2][2]);
    for (int i = 0; i < 4; i++) begin
      prod_c[i] = qalu_pkg::sat_comp(64'((acc[i] + HALF) >>> FRAC_BITS));
    end
    case (cls2)
      qalu_pkg::CL_MUL, qalu_pkg::CL_ERR:                 res_c = prod_c;
      qalu_pkg::CL_CONJ, qalu_pkg::CL_ADD, qalu_pkg::CL_SUB: res_c = simp2;
      default:                                            res_c = '0;
    endcase
    s_c = SW'($unsigned(sq2[0])) + SW'($unsigned(sq2[1]))
        + SW'($unsigned(sq2[2])) + SW'($unsigned(sq2[3]));
  end

  logic            v3;
  logic            norm3;
  qalu_pkg::quat_t res3;
  qalu_pkg::quat_t a3;
  logic [SW-1:0]   s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      norm3 <= (cls2 == qalu_pkg::CL_NORM);
      res3  <= res_c;
      a3    <= a2;
      s3    <= s_c;
    end
  end

  // normalize path and matching delay for the other ops
  qalu_pkg::quat_t norm_r;
  logic            norm_zero;

  qalu_norm #(
    .FRAC_BITS (FRAC_BITS)
  ) u_norm (
    .clk  (clk),
    .en   (en),
    .s    (s3),
    .a    (a3),
    .r    (norm_r),
    .zero (norm_zero)
  );

  logic            dv [NL];
  logic            dn [NL];
  qalu_pkg::quat_t dd [NL];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NL; k++) begin
        dv[k] <= 1'b0;
      end
    end else if (en) begin
      dv[0] <= v3;
      for (int k = 1; k < NL; k++) begin
        dv[k] <= dv[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn[0] <= norm3;
      dd[0] <= res3;
      for (int k = 1; k < NL; k++) begin
        dn[k] <= dn[k-1];
        dd[k] <= dd[k-1];
      end
    end
  end

  // output register
  qalu_pkg::quat_t fin;

  assign fin = dn[NL-1] ? norm_r : dd[NL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= dv[NL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.r_x       <= signed'(fin[0]);
      rsp.r_y       <= signed'(fin[1]);
      rsp.r_z       <= signed'(fin[2]);
      rsp.r_w       <= signed'(fin[3]);
      rsp.zero_norm <= dn[NL-1] && norm_zero;
    end
  end

endmodule

// ===== hdl/quaternion_alu.sv =====
// ----------------------------------------------------------------------------
// quaternion_alu
// quaternion arithmetic unit: conjugate, add, subtract, hamilton product,
// error product and normalize on signed fixed-point components
// ----------------------------------------------------------------------------
//
//  channel   handshake      payload  accepted when
//  -------   ------------   -------  ------------------
//  request   push / full    req      push high, full low
//  result    empty / pop    rsp      pop high, empty low
//
//  one transaction per cycle sustained while results are taken, one result
//  per transaction; the pipeline depth is set by the square-root digit
//  stages and the quotient bit stages of the normalize path, matched by
//  a delay line that the other ops travel
//  reset is synchronous and clears all valid state; results come in order
//  a stall on the result side freezes the pipeline; the front register
//  and queue keep taking requests until they fill
//
module quaternion_alu #(
  parameter int FRAC_BITS   = qalu_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = qalu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  qalu_pkg::req_t req,
  output logic           empty,
  input  logic           pop,
  output qalu_pkg::rsp_t rsp
);

  // front to queue
  logic            q_push;
  logic            q_full;
  qalu_pkg::work_t q_in;

  // queue to back
  logic            q_pop;
  logic            q_empty;
  qalu_pkg::work_t q_out;

  // front: takes the transaction, decodes the opcode
  qalu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  // decoupling queue so each side stalls on its own
  qalu_fifo #(
    .W     ($bits(qalu_pkg::work_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .full  (q_full),
    .din   (q_in),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_out)
  );

  // back: arithmetic pipeline ending in the result register
  qalu_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .rsp     (rsp)
  );

endmodule

// ===== hdl/qalu_chk.sv =====
// ----------------------------------------------------------------------------
// qalu_chk
// port-level checks of the quaternion unit, bound to the top level
// ----------------------------------------------------------------------------
`include "quaternion_alu_assert.svh"

module qalu_chk (
  input logic           clk,
  input logic           rst,
  input logic           push,
  input logic           full,
  input qalu_pkg::req_t req,
  input logic           empty,
  input logic           pop,
  input qalu_pkg::rsp_t rsp
);

  // nothing waits on the result side after reset
  `QALU_AST_RESET(a_rst_empty, clk, rst, empty)

  // request side is open after reset
  `QALU_AST_RESET(a_rst_open, clk, rst, !full)

  // a waiting result holds until taken
  `QALU_AST_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(rsp))

  // zero magnitude flag comes only with a zero quaternion
  `QALU_AST_SAME(a_zero, clk, rst, !empty && rsp.zero_norm,
                 rsp.r_x == 0 && rsp.r_y == 0 && rsp.r_z == 0 && rsp.r_w == 0)

endmodule

bind quaternion_alu qalu_chk u_chk (.*);

// ===== verif/qalu_checker.sv =====
// ----------------------------------------------------------------------------
// qalu_checker
// watches both channels of the quaternion unit, predicts each result from
// the accepted request and compares it field by field in arrival order
// ----------------------------------------------------------------------------
module qalu_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic           full,
  input  qalu_pkg::req_t req,
  input  logic           empty,
  input  logic           pop,
  input  qalu_pkg::rsp_t rsp,
  output int             fail_count,
  output int             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 14;
  localparam longint CMAX = 32767;
  localparam longint CMIN = -32768;

  qalu_pkg::rsp_t expected_rsp_q[$];

  function automatic qalu_pkg::comp_t clamp(input longint v);
    if (v > CMAX) begin
      return qalu_pkg::comp_t'(CMAX);
    end else if (v < CMIN) begin
      return qalu_pkg::comp_t'(CMIN);
    end
    return qalu_pkg::comp_t'(v);
  endfunction

  // floor of (sum of four products + half lsb) >>> FB, clamped; exact in 64 bits
  function automatic qalu_pkg::comp_t round4(input longint p0, input longint p1,
                                             input longint p2, input longint p3);
    longint s;
    s = p0 + p1 + p2 + p3 + (64'sd1 <<< (FB - 1));
    return clamp(s >>> FB);
  endfunction

  function automatic longint int_sqrt(input longint v);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= v) begin
        r = r + (64'sd1 <<< b);
      end
    end
    return r;
  endfunction

  function automatic qalu_pkg::comp_t unit_comp(input longint c, input longint mag);
    longint m;
    longint q;
    m = (c < 0) ? -c : c;
    q = ((m <<< FB) + mag / 2) / mag;
    return clamp((c < 0) ? -q : q);
  endfunction

  function automatic qalu_pkg::rsp_t quat_predict(input qalu_pkg::req_t t);
    qalu_pkg::rsp_t o;
    longint ax, ay, az, aw, bx, by, bz, bw, s, mag;
    ax = t.a_x; ay = t.a_y; az = t.a_z; aw = t.a_w;
    bx = t.b_x; by = t.b_y; bz = t.b_z; bw = t.b_w;
    o = '0;
    case (t.op)
      qalu_pkg::OP_CONJ: begin
        o.r_x = clamp(-ax); o.r_y = clamp(-ay); o.r_z = clamp(-az); o.r_w = clamp(aw);
      end
      qalu_pkg::OP_ADD: begin
        o.r_x = clamp(ax + bx); o.r_y = clamp(ay + by);
        o.r_z = clamp(az + bz); o.r_w = clamp(aw + bw);
      end
      qalu_pkg::OP_SUB: begin
        o.r_x = clamp(ax - bx); o.r_y = clamp(ay - by);
        o.r_z = clamp(az - bz); o.r_w = clamp(aw - bw);
      end
      qalu_pkg::OP_MUL: begin
        o.r_x = round4(aw * bx, bw * ax, ay * bz, -(az * by));
        o.r_y = round4(aw * by, bw * ay, az * bx, -(ax * bz));
        o.r_z = round4(aw * bz, bw * az, ax * by, -(ay * bx));
        o.r_w = round4(aw * bw, -(ax * bx), -(ay * by), -(az * bz));
      end
      qalu_pkg::OP_ERR: begin
        o.r_x = round4(bw * ax, -(aw * bx), bz * ay, -(by * az));
        o.r_y = round4(bw * ay, -(aw * by), bx * az, -(bz * ax));
        o.r_z = round4(bw * az, -(aw * bz), by * ax, -(bx * ay));
        o.r_w = round4(bw * aw, bx * ax, by * ay, bz * az);
      end
      qalu_pkg::OP_NORM: begin
        s = ax * ax + ay * ay + az * az + aw * aw;
        if (s == 0) begin
          o.zero_norm = 1'b1;
        end else begin
          mag = int_sqrt(s);
          o.r_x = unit_comp(ax, mag); o.r_y = unit_comp(ay, mag);
          o.r_z = unit_comp(az, mag); o.r_w = unit_comp(aw, mag);
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign pending = expected_rsp_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    qalu_pkg::rsp_t want;
    if (!rst) begin
      if (push && !full) begin
        expected_rsp_q.push_back(quat_predict(req));
      end
      if (pop && !empty) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.r_x !== want.r_x) report_mismatch("r_x", rsp.r_x, want.r_x);
          if (rsp.r_y !== want.r_y) report_mismatch("r_y", rsp.r_y, want.r_y);
          if (rsp.r_z !== want.r_z) report_mismatch("r_z", rsp.r_z, want.r_z);
          if (rsp.r_w !== want.r_w) report_mismatch("r_w", rsp.r_w, want.r_w);
          if (rsp.zero_norm !== want.zero_norm) begin
            report_mismatch("zero_norm", rsp.zero_norm, want.zero_norm);
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_quaternion_alu.sv =====
// ----------------------------------------------------------------------------
// tb_quaternion_alu
// drives directed and random quaternion requests with random idle cycles
// and a long result-side hold-off; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_quaternion_alu;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1330;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 60;

  logic           clk;
  logic           rst;
  logic           push;
  logic           full;
  qalu_pkg::req_t req;
  logic           empty;
  logic           pop;
  qalu_pkg::rsp_t rsp;
  int             fail_count;
  int             pending;

  // stimulus shaping flags
  bit   calm;        // no idling on either side
  bit   hold_off;    // receiver refuses results for a while
  bit   stim_done;
  int   idle_cycles;

  qalu_pkg::req_t stim_q[$];

  quaternion_alu u_dut (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .req  (req),
    .empty(empty),
    .pop  (pop),
    .rsp  (rsp)
  );

  qalu_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .empty     (empty),
    .pop       (pop),
    .rsp       (rsp),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // component picker: random half the time, else an extreme, zero, a small value or 16'h4000
  function automatic qalu_pkg::comp_t pick_comp();
    case ($urandom_range(0, 9))
      0: return qalu_pkg::comp_t'(16'h8000);
      1: return qalu_pkg::comp_t'(16'h7fff);
      2: return qalu_pkg::comp_t'(0);
      3: return qalu_pkg::comp_t'($urandom_range(0, 32) - 16);
      4: return qalu_pkg::comp_t'(16'h4000);
      default: return qalu_pkg::comp_t'($urandom);
    endcase
  endfunction

  function automatic qalu_pkg::req_t make_req(input logic [2:0] op,
                                              input qalu_pkg::comp_t ax,
                                              input qalu_pkg::comp_t ay,
                                              input qalu_pkg::comp_t az,
                                              input qalu_pkg::comp_t aw,
                                              input qalu_pkg::comp_t bx,
                                              input qalu_pkg::comp_t by,
                                              input qalu_pkg::comp_t bz,
                                              input qalu_pkg::comp_t bw);
    qalu_pkg::req_t t;
    t.op = op;
    t.a_x = ax; t.a_y = ay; t.a_z = az; t.a_w = aw;
    t.b_x = bx; t.b_y = by; t.b_z = bz; t.b_w = bw;
    return t;
  endfunction

  // sender: one request per accepted transaction, random gaps
  initial begin
    qalu_pkg::req_t t;
    rst       <= 1'b1;
    push      <= 1'b0;
    req       <= '0;
    calm      = 1'b0;
    hold_off  = 1'b0;
    stim_done = 1'b0;

    // directed: extremes, every op and the special cases
    stim_q.push_back(make_req(qalu_pkg::OP_CONJ, 16'h8000, 16'h7fff, 0, 16'h8000,
                              1, 2, 3, 4));
    stim_q.push_back(make_req(qalu_pkg::OP_ADD, 16'h7fff, 16'h8000, 1, 16'h4000,
                              16'h7fff, 16'h8000, -1, 16'h4000));
    stim_q.push_back(make_req(qalu_pkg::OP_SUB, 16'h7fff, 16'h8000, 0, 5,
                              16'h8000, 16'h7fff, 0, 5));
    stim_q.push_back(make_req(qalu_pkg::OP_MUL, 0, 0, 0, 16'h4000,
                              100, -200, 300, 16'h4000));
    stim_q.push_back(make_req(qalu_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                              16'h8000, 16'h8000, 16'h8000, 16'h8000));
    stim_q.push_back(make_req(qalu_pkg::OP_MUL, 1, 1, 1, 1, 16'h2000, 16'h2000, 0, 0));
    stim_q.push_back(make_req(qalu_pkg::OP_ERR, 1000, 2000, 3000, 16'h4000,
                              1000, 2000, 3000, 16'h4000));
    stim_q.push_back(make_req(qalu_pkg::OP_ERR, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                              16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
    stim_q.push_back(make_req(qalu_pkg::OP_NORM, 0, 0, 0, 0,
                              16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    stim_q.push_back(make_req(qalu_pkg::OP_NORM, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                              0, 0, 0, 0));
    stim_q.push_back(make_req(qalu_pkg::OP_NORM, 0, 0, 0, 1, 0, 0, 0, 0));
    stim_q.push_back(make_req(qalu_pkg::OP_NORM, 3, -4, 0, 0, 9, 9, 9, 9));
    stim_q.push_back(make_req(qalu_pkg::OP_NORM, 16'h7fff, 0, 0, 0, 0, 0, 0, 0));
    stim_q.push_back(make_req(3'd6, 1, 2, 3, 4, 5, 6, 7, 8));
    stim_q.push_back(make_req(3'd7, 16'h8000, 16'h7fff, 1, 1, 1, 1, 1, 1));
    stim_q.push_back(make_req(qalu_pkg::OP_CONJ, 16'hffff, 16'h5555, 16'haaaa, 16'hffff,
                              16'hffff, 16'h5555, 16'haaaa, 16'hffff));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      t = make_req(($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                 : 3'($urandom_range(0, 5)),
                   pick_comp(), pick_comp(), pick_comp(), pick_comp(),
                   pick_comp(), pick_comp(), pick_comp(), pick_comp());
      stim_q.push_back(t);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < stim_q.size(); n++) begin
      // a calm stretch in the middle, a long hold-off early on
      calm     = (n >= 600 && n < 800);
      hold_off = (n == 300) ? 1'b1 : hold_off;
      while (!calm && $urandom_range(0, 99) < 18) begin
        push <= 1'b0;
        @(posedge clk);
      end
      push <= 1'b1;
      req  <= stim_q[n];
      @(posedge clk);
      while (full) @(posedge clk);
    end
    push <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random pop, held low during the hold-off stretch
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        // hold off long enough for the unit to fill and stall its input
        pop <= 1'b0;
        repeat (120) @(posedge clk);
        hold_off = 1'b0;
      end
      pop <= calm || ($urandom_range(0, 99) >= 18);
    end
  end

  // watchdog: counts cycles in which neither side moves a transaction
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // verdict once every expected result has come back
  initial begin
    wait (stim_done);
    // let the checker log the last accepted request first
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/qalu_pkg.sv
hdl/qalu_fifo.sv
hdl/qalu_front.sv
hdl/qalu_norm.sv
hdl/qalu_back.sv
hdl/quaternion_alu.sv
hdl/qalu_chk.sv
verif/qalu_checker.sv
verif/tb_quaternion_alu.sv
